// File: sv/lorenz_euler_step_unit_macros.svh
// assertion macros for the lorenz euler step unit checker
`ifndef LORENZ_EULER_STEP_UNIT_MACROS_SVH
`define LORENZ_EULER_STEP_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define LES_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define LES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/les_pkg.sv
// shared types, constants and saturation helpers of the lorenz euler step unit
package les_pkg;

	localparam int FRAC_BITS_DEF   = 20;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int DATA_W = 32;
	localparam int DT_W   = 31;
	localparam int RUN_W  = 16;
	localparam int IDX_W  = 16;
	localparam int CFG_W  = 3;
	localparam int N_OPS  = 7;
	localparam int ISSUE_W = $clog2(N_OPS);

	localparam logic [CFG_W-1:0] CFG_SIGMA      = 3'd0;
	localparam logic [CFG_W-1:0] CFG_BETA       = 3'd1;
	localparam logic [CFG_W-1:0] CFG_RHO        = 3'd2;
	localparam logic [CFG_W-1:0] CFG_TIME_STEP  = 3'd3;
	localparam logic [CFG_W-1:0] CFG_START_X    = 3'd4;
	localparam logic [CFG_W-1:0] CFG_START_Y    = 3'd5;
	localparam logic [CFG_W-1:0] CFG_START_Z    = 3'd6;
	localparam logic [CFG_W-1:0] CFG_RUN_LENGTH = 3'd7;

	localparam logic [RUN_W-1:0] RUN_LENGTH_RST = 16'd50000;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_ISSUE,
		S_FLUSH,
		S_DONE
	} state_t;

	// multiplier operations in issue order
	typedef enum logic [ISSUE_W-1:0] {
		OP_DX,
		OP_DY,
		OP_Q,
		OP_DZ,
		OP_NX,
		OP_NY,
		OP_NZ
	} op_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic issue;
		op_t  op;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic wb_busy;
	} status_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[DATA_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[DATA_W-1:0];
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > SAT_MAX) || (v < SAT_MIN);
	endfunction

endpackage

// File: sv/les_in_if.sv
// request channel carrying the restart flag
interface les_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// File: sv/les_out_if.sv
// result channel carrying the new point, step index and flags
interface les_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [les_pkg::DATA_W-1:0] pos_x;
	logic signed [les_pkg::DATA_W-1:0] pos_y;
	logic signed [les_pkg::DATA_W-1:0] pos_z;
	logic [les_pkg::IDX_W-1:0]         step_index;
	logic                              end_of_run;
	logic                              overflow;

	modport source (
		output valid, output pos_x, output pos_y, output pos_z,
		output step_index, output end_of_run, output overflow,
		input ready
	);
	modport sink (
		input valid, input pos_x, input pos_y, input pos_z,
		input step_index, input end_of_run, input overflow,
		output ready
	);
endinterface

// File: sv/lorenz_euler_step_unit.sv
// top level of the lorenz euler step unit
//
// channel   dir   payload                                              handshake
// step      in    restart                                              valid/ready
// result    out   pos_x pos_y pos_z step_index end_of_run overflow     valid/ready
// cfg       in    cfg_index cfg_data                                   cfg_we
//
// one request at a time, taken only in idle: a prep step, seven products through the
// single 32x32 multiplier, each registered and then written back, a wait for the last
// writeback, a load of the output register and a return to idle for the next request
// the result sits in an output register; a stalled result holds the engine in its last state
// reset returns control, coefficients, point and step count to their reset values at once
module lorenz_euler_step_unit #(
	parameter int FRAC_BITS   = les_pkg::FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = les_pkg::COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [les_pkg::CFG_W-1:0]  cfg_index,
	input  logic [les_pkg::DATA_W-1:0] cfg_data,
	les_in_if.sink                     step,
	les_out_if.source                  result
);

	les_pkg::cmd_t    cmd;
	les_pkg::status_t status;

	les_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (step.valid),
		.in_ready  (step.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	les_datapath #(
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.restart    (step.restart),
		.cmd        (cmd),
		.status     (status),
		.pos_x      (result.pos_x),
		.pos_y      (result.pos_y),
		.pos_z      (result.pos_z),
		.step_index (result.step_index),
		.end_of_run (result.end_of_run),
		.overflow   (result.overflow)
	);

endmodule

// File: sv/les_ctrl.sv
// controller: sequences one euler step over the shared multiplier
module les_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  les_pkg::status_t  status,
	output les_pkg::cmd_t     cmd
);

	les_pkg::state_t state_q, state_d;
	logic [les_pkg::ISSUE_W-1:0] issue_q;
	logic out_valid_q;
	logic last_issue;

	assign last_issue = (issue_q == les_pkg::ISSUE_W'(les_pkg::OP_NZ));

	always_comb begin
		state_d = state_q;
		case (state_q)
			les_pkg::S_IDLE: begin
				if (in_valid) state_d = les_pkg::S_PREP;
			end
			les_pkg::S_PREP: begin
				state_d = les_pkg::S_ISSUE;
			end
			les_pkg::S_ISSUE: begin
				if (last_issue) state_d = les_pkg::S_FLUSH;
			end
			les_pkg::S_FLUSH: begin
				if (!status.wb_busy) state_d = les_pkg::S_DONE;
			end
			les_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) state_d = les_pkg::S_IDLE;
			end
			default: begin
				state_d = les_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.prep   = 1'b0;
		cmd.issue  = 1'b0;
		cmd.op     = les_pkg::op_t'(issue_q);
		cmd.finish = 1'b0;
		case (state_q)
			les_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			les_pkg::S_PREP: begin
				cmd.prep = 1'b1;
			end
			les_pkg::S_ISSUE: begin
				cmd.issue = 1'b1;
			end
			les_pkg::S_FLUSH: begin
			end
			les_pkg::S_DONE: begin
				cmd.finish = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= les_pkg::S_IDLE;
			issue_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				issue_q <= '0;
			end else if (cmd.issue) begin
				issue_q <= issue_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/les_datapath.sv
// datapath: coefficient registers, point state, shared multiplier and writeback
module les_datapath #(
	parameter int FRAC_BITS   = les_pkg::FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = les_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [les_pkg::CFG_W-1:0]         cfg_index,
	input  logic [les_pkg::DATA_W-1:0]        cfg_data,
	input  logic                              restart,
	input  les_pkg::cmd_t                     cmd,
	output les_pkg::status_t                  status,
	output logic signed [les_pkg::DATA_W-1:0] pos_x,
	output logic signed [les_pkg::DATA_W-1:0] pos_y,
	output logic signed [les_pkg::DATA_W-1:0] pos_z,
	output logic [les_pkg::IDX_W-1:0]         step_index,
	output logic                              end_of_run,
	output logic                              overflow
);

	localparam int DW = les_pkg::DATA_W;
	localparam longint ONE = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [DW-1:0] SIGMA_RST = DW'(10 * ONE);
	localparam logic signed [DW-1:0] BETA_RST  = DW'((2666 * ONE + 500) / 1000);
	localparam logic signed [DW-1:0] RHO_RST   = DW'(28 * ONE);
	localparam logic [les_pkg::DT_W-1:0] DT_RST = les_pkg::DT_W'((ONE + 500) / 1000);
	localparam logic signed [DW-1:0] START_RST = DW'(ONE);
	localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

	logic signed [DW-1:0] sigma_q, beta_q, rho_q, start_x_q, start_y_q, start_z_q;
	logic [les_pkg::DT_W-1:0]  dt_q;
	logic [les_pkg::RUN_W-1:0] run_length_q;

	logic signed [DW-1:0] cur_x_q, cur_y_q, cur_z_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic signed [DW-1:0] d1_q, d2_q, dx_q, dy_q, dz_q, q_q;
	logic ovf_q;

	logic signed [63:0] prod_s1;
	les_pkg::op_t       wop_s1;
	logic               wvalid_s1;

	logic signed [DW-1:0] out_x_q, out_y_q, out_z_q;
	logic [les_pkg::IDX_W-1:0] out_idx_q;
	logic out_end_q, out_ovf_q;

	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [63:0] diff1, diff2;
	logic signed [63:0] rnd_w, sum_w;
	logic signed [DW-1:0] rsat, ssat;
	logic rovf, sovf, wb_ovf;
	logic [COUNT_WIDTH-1:0] last_idx;
	logic [31:0] idx_ext;
	logic at_end;

	// operand selection for the shared multiplier
	always_comb begin
		case (cmd.op)
			les_pkg::OP_DX: begin mul_a = sigma_q;  mul_b = d1_q; end
			les_pkg::OP_DY: begin mul_a = cur_x_q;  mul_b = d2_q; end
			les_pkg::OP_Q:  begin mul_a = cur_x_q;  mul_b = cur_y_q; end
			les_pkg::OP_DZ: begin mul_a = beta_q;   mul_b = cur_z_q; end
			les_pkg::OP_NX: begin mul_a = {1'b0, dt_q}; mul_b = dx_q; end
			les_pkg::OP_NY: begin mul_a = {1'b0, dt_q}; mul_b = dy_q; end
			les_pkg::OP_NZ: begin mul_a = {1'b0, dt_q}; mul_b = dz_q; end
			default: begin mul_a = sigma_q; mul_b = d1_q; end
		endcase
	end

	assign prod  = 64'(mul_a) * 64'(mul_b);
	assign diff1 = 64'(cur_y_q) - 64'(cur_x_q);
	assign diff2 = 64'(rho_q) - 64'(cur_z_q);

	// round to nearest, ties up
	assign rnd_w = (prod_s1 + RND_HALF) >>> FRAC_BITS;
	assign rsat  = les_pkg::sat32(rnd_w);
	assign rovf  = les_pkg::ovf32(rnd_w);

	always_comb begin
		case (wop_s1)
			les_pkg::OP_DY: sum_w = 64'(rsat) - 64'(cur_y_q);
			les_pkg::OP_DZ: sum_w = 64'(q_q) - 64'(rsat);
			les_pkg::OP_NX: sum_w = 64'(cur_x_q) + rnd_w;
			les_pkg::OP_NY: sum_w = 64'(cur_y_q) + rnd_w;
			les_pkg::OP_NZ: sum_w = 64'(cur_z_q) + rnd_w;
			default:        sum_w = rnd_w;
		endcase
	end

	assign ssat = les_pkg::sat32(sum_w);
	assign sovf = les_pkg::ovf32(sum_w);

	always_comb begin
		case (wop_s1)
			les_pkg::OP_DX, les_pkg::OP_Q: wb_ovf = rovf;
			les_pkg::OP_DY, les_pkg::OP_DZ: wb_ovf = rovf | sovf;
			default: wb_ovf = sovf;
		endcase
	end

	assign last_idx = COUNT_WIDTH'(32'(run_length_q) - 32'd1);
	assign idx_ext  = 32'(cnt_q);
	assign at_end   = (cnt_q == last_idx);

	assign status.wb_busy = wvalid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q      <= SIGMA_RST;
			beta_q       <= BETA_RST;
			rho_q        <= RHO_RST;
			dt_q         <= DT_RST;
			start_x_q    <= START_RST;
			start_y_q    <= START_RST;
			start_z_q    <= START_RST;
			run_length_q <= les_pkg::RUN_LENGTH_RST;
			cur_x_q      <= START_RST;
			cur_y_q      <= START_RST;
			cur_z_q      <= START_RST;
			cnt_q        <= '0;
			wvalid_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					les_pkg::CFG_SIGMA:      sigma_q      <= cfg_data;
					les_pkg::CFG_BETA:       beta_q       <= cfg_data;
					les_pkg::CFG_RHO:        rho_q        <= cfg_data;
					les_pkg::CFG_TIME_STEP:  dt_q         <= cfg_data[les_pkg::DT_W-1:0];
					les_pkg::CFG_START_X:    start_x_q    <= cfg_data;
					les_pkg::CFG_START_Y:    start_y_q    <= cfg_data;
					les_pkg::CFG_START_Z:    start_z_q    <= cfg_data;
					les_pkg::CFG_RUN_LENGTH: run_length_q <= cfg_data[les_pkg::RUN_W-1:0];
					default: begin
					end
				endcase
			end
			wvalid_s1 <= cmd.issue;
			if (cmd.load && restart) begin
				cur_x_q <= start_x_q;
				cur_y_q <= start_y_q;
				cur_z_q <= start_z_q;
				cnt_q   <= '0;
			end else begin
				if (wvalid_s1) begin
					case (wop_s1)
						les_pkg::OP_NX: cur_x_q <= ssat;
						les_pkg::OP_NY: cur_y_q <= ssat;
						les_pkg::OP_NZ: cur_z_q <= ssat;
						default: begin
						end
					endcase
				end
				if (cmd.finish) begin
					cnt_q <= at_end ? '0 : cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			d1_q  <= les_pkg::sat32(diff1);
			d2_q  <= les_pkg::sat32(diff2);
			ovf_q <= les_pkg::ovf32(diff1) | les_pkg::ovf32(diff2);
		end else if (wvalid_s1) begin
			ovf_q <= ovf_q | wb_ovf;
			case (wop_s1)
				les_pkg::OP_DX: dx_q <= rsat;
				les_pkg::OP_DY: dy_q <= ssat;
				les_pkg::OP_Q:  q_q  <= rsat;
				les_pkg::OP_DZ: dz_q <= ssat;
				default: begin
				end
			endcase
		end
		if (cmd.issue) begin
			prod_s1 <= prod;
			wop_s1  <= cmd.op;
		end
		if (cmd.finish) begin
			out_x_q   <= cur_x_q;
			out_y_q   <= cur_y_q;
			out_z_q   <= cur_z_q;
			out_idx_q <= idx_ext[les_pkg::IDX_W-1:0];
			out_end_q <= at_end;
			out_ovf_q <= ovf_q;
		end
	end

	assign pos_x      = out_x_q;
	assign pos_y      = out_y_q;
	assign pos_z      = out_z_q;
	assign step_index = out_idx_q;
	assign end_of_run = out_end_q;
	assign overflow   = out_ovf_q;

endmodule

// File: sv/les_checker.sv
// port-level checker for the lorenz euler step unit, bound to the top level
`include "lorenz_euler_step_unit_macros.svh"

module les_checker (
	input logic       clk,
	input logic       arst_n,
	les_in_if.sink    step,
	les_out_if.source result
);

	`LES_ASSERT_NEXT(a_busy_after_request, step.valid && step.ready, !step.ready, "ready after request")
	`LES_ASSERT_SAME(a_result_from_busy, $rose(result.valid), !$past(step.ready), "result while idle")
	`LES_ASSERT_NEXT(a_result_held, result.valid && !result.ready, result.valid, "result dropped")
	`LES_ASSERT_NEXT(a_payload_held, result.valid && !result.ready, $stable(result.pos_x) && $stable(result.step_index) && $stable(result.overflow), "payload moved")

endmodule

bind lorenz_euler_step_unit les_checker u_les_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.step   (step),
	.result (result)
);

// File: sim/les_step_checker.sv
// checker for the lorenz euler step unit: tracks the register writes, predicts each result and compares
module les_step_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [les_pkg::CFG_W-1:0]  cfg_index,
	input  logic [les_pkg::DATA_W-1:0] cfg_data,
	les_in_if                          step,
	les_out_if                         result,
	output int                         mismatches,
	output int                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = les_pkg::FRAC_BITS_DEF;
	localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC - 1);
	localparam logic signed [63:0] POS_LIMIT = 64'sd2147483647;
	localparam logic signed [63:0] NEG_LIMIT = -64'sd2147483648;

	localparam logic signed [31:0] SIGMA_RST = 32'sd10485760;
	localparam logic signed [31:0] BETA_RST  = 32'sd2795504;
	localparam logic signed [31:0] RHO_RST   = 32'sd29360128;
	localparam logic [30:0]        DT_RST    = 31'd1049;
	localparam logic signed [31:0] ORIGIN_RST = 32'sd1048576;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        idx;
		logic               eor;
		logic               ovf;
	} point_t;

	logic signed [31:0] k_sigma, k_beta, k_rho;
	logic [30:0]        k_dt;
	logic signed [31:0] org_x, org_y, org_z;
	logic [15:0]        k_run;

	logic signed [31:0] px, py, pz;
	logic [15:0]        count;
	logic               sat_hit;

	point_t expected_points[$];
	point_t seen, want;
	int     result_count;

	function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
		if (v > POS_LIMIT) begin
			sat_hit = 1'b1;
			return POS_LIMIT;
		end
		if (v < NEG_LIMIT) begin
			sat_hit = 1'b1;
			return NEG_LIMIT;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] rnd_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] p;
		p = a * b + HALF_LSB;
		return p >>> FRAC;
	endfunction

	// one euler step from the current point, updates the tracked state
	function automatic point_t advance(input logic restart);
		logic signed [63:0] x, y, z, s, b, rh, dt;
		logic signed [63:0] d1, dx, d2, p, dy, q, bz, dz, nx, ny, nz;
		logic [15:0]        last;
		point_t             r;
		if (restart) begin
			px = org_x;
			py = org_y;
			pz = org_z;
			count = '0;
		end
		sat_hit = 1'b0;
		x = px;
		y = py;
		z = pz;
		s = k_sigma;
		b = k_beta;
		rh = k_rho;
		dt = {33'b0, k_dt};

		d1 = clamp(y - x);
		dx = clamp(rnd_mul(s, d1));
		d2 = clamp(rh - z);
		p = clamp(rnd_mul(x, d2));
		dy = clamp(p - y);
		q = clamp(rnd_mul(x, y));
		bz = clamp(rnd_mul(b, z));
		dz = clamp(q - bz);

		nx = clamp(x + rnd_mul(dt, dx));
		ny = clamp(y + rnd_mul(dt, dy));
		nz = clamp(z + rnd_mul(dt, dz));

		last = k_run - 16'd1;
		r.x = nx[31:0];
		r.y = ny[31:0];
		r.z = nz[31:0];
		r.idx = count;
		r.eor = (count == last);
		r.ovf = sat_hit;

		px = nx[31:0];
		py = ny[31:0];
		pz = nz[31:0];
		count = r.eor ? 16'd0 : count + 16'd1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_sigma = SIGMA_RST;
			k_beta = BETA_RST;
			k_rho = RHO_RST;
			k_dt = DT_RST;
			org_x = ORIGIN_RST;
			org_y = ORIGIN_RST;
			org_z = ORIGIN_RST;
			k_run = les_pkg::RUN_LENGTH_RST;
			px = ORIGIN_RST;
			py = ORIGIN_RST;
			pz = ORIGIN_RST;
			count = '0;
			expected_points.delete();
			result_count = 0;
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					les_pkg::CFG_SIGMA:      k_sigma = cfg_data;
					les_pkg::CFG_BETA:       k_beta = cfg_data;
					les_pkg::CFG_RHO:        k_rho = cfg_data;
					les_pkg::CFG_TIME_STEP:  k_dt = cfg_data[30:0];
					les_pkg::CFG_START_X:    org_x = cfg_data;
					les_pkg::CFG_START_Y:    org_y = cfg_data;
					les_pkg::CFG_START_Z:    org_z = cfg_data;
					les_pkg::CFG_RUN_LENGTH: k_run = cfg_data[15:0];
					default: ;
				endcase
			end

			if (result.valid && result.ready) begin
				seen.x = result.pos_x;
				seen.y = result.pos_y;
				seen.z = result.pos_z;
				seen.idx = result.step_index;
				seen.eor = result.end_of_run;
				seen.ovf = result.overflow;
				if (expected_points.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d with no request pending: x=%h y=%h z=%h idx=%0d eor=%b ovf=%b",
							result_count, seen.x, seen.y, seen.z, seen.idx, seen.eor, seen.ovf);
				end else begin
					want = expected_points.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d expected x=%h y=%h z=%h idx=%0d eor=%b ovf=%b",
								result_count, want.x, want.y, want.z, want.idx, want.eor, want.ovf);
							$display("result %0d actual   x=%h y=%h z=%h idx=%0d eor=%b ovf=%b",
								result_count, seen.x, seen.y, seen.z, seen.idx, seen.eor, seen.ovf);
						end
					end
				end
				result_count++;
			end

			if (step.valid && step.ready)
				expected_points.push_back(advance(step.restart));

			outstanding = expected_points.size();
		end
	end

endmodule

// File: sim/tb.sv
// testbench top of the lorenz euler step unit: stimulus, register phases and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT = 400000;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [les_pkg::CFG_W-1:0]  cfg_index;
	logic [les_pkg::DATA_W-1:0] cfg_data;
	int                         mismatches;
	int                         outstanding;
	int                         sent;
	int                         cycle_count;

	les_in_if  step_ch ();
	les_out_if result_ch ();

	lorenz_euler_step_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step_ch),
		.result    (result_ch)
	);

	les_step_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.step        (step_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lorenz_euler_step_unit regression: fail");
			$finish;
		end
	end

	// result side back-pressure in segments of differing character
	initial begin
		int seg;
		int mode;
		int k;
		result_ch.ready = 1'b0;
		forever begin
			seg = $urandom_range(10, 80);
			mode = $urandom_range(0, 3);
			for (k = 0; k < seg; k++) begin
				@(negedge clk);
				case (mode)
					0: result_ch.ready = 1'b1;
					1: result_ch.ready = $urandom_range(0, 1);
					2: result_ch.ready = (k % 5) != 0;
					default: result_ch.ready = ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	task automatic write_reg(input logic [les_pkg::CFG_W-1:0] idx,
			input logic [les_pkg::DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_one(input logic restart);
		step_ch.valid = 1'b1;
		step_ch.restart = restart;
		@(posedge clk);
		while (!step_ch.ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_batch(input int n, input int restart_pct);
		int left;
		int burst;
		int gap;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 10);
			if (burst > left)
				burst = left;
			left -= burst;
			repeat (burst) send_one($urandom_range(1, 100) <= restart_pct);
			step_ch.valid = 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle();
		step_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic write_defaults();
		write_reg(les_pkg::CFG_SIGMA, 32'd10485760);
		write_reg(les_pkg::CFG_BETA, 32'd2795504);
		write_reg(les_pkg::CFG_RHO, 32'd29360128);
		write_reg(les_pkg::CFG_TIME_STEP, 32'd1049);
		write_reg(les_pkg::CFG_START_X, 32'd1048576);
		write_reg(les_pkg::CFG_START_Y, 32'd1048576);
		write_reg(les_pkg::CFG_START_Z, 32'd1048576);
	endtask

	task automatic random_config(input int kind);
		if (kind <= 5) begin
			write_reg(les_pkg::CFG_SIGMA, $urandom_range(0, 32'd4194304) + 32'd8388608);
			write_reg(les_pkg::CFG_BETA, $urandom_range(32'd2097152, 32'd3145728));
			write_reg(les_pkg::CFG_RHO, $urandom_range(32'd20971520, 32'd41943040));
			write_reg(les_pkg::CFG_TIME_STEP, $urandom_range(0, 20000));
			write_reg(les_pkg::CFG_START_X, $urandom_range(0, 32'd62914560) - 32'd31457280);
			write_reg(les_pkg::CFG_START_Y, $urandom_range(0, 32'd62914560) - 32'd31457280);
			write_reg(les_pkg::CFG_START_Z, $urandom_range(0, 32'd62914560) - 32'd31457280);
			write_reg(les_pkg::CFG_RUN_LENGTH, $urandom_range(1, 40));
		end else if (kind <= 7) begin
			write_reg(les_pkg::CFG_SIGMA, $urandom);
			write_reg(les_pkg::CFG_BETA, $urandom);
			write_reg(les_pkg::CFG_RHO, $urandom);
			write_reg(les_pkg::CFG_TIME_STEP, $urandom);
			write_reg(les_pkg::CFG_START_X, $urandom);
			write_reg(les_pkg::CFG_START_Y, $urandom);
			write_reg(les_pkg::CFG_START_Z, $urandom);
			write_reg(les_pkg::CFG_RUN_LENGTH, $urandom);
		end else if (kind == 8) begin
			write_reg(les_pkg::CFG_SIGMA, pick_extreme());
			write_reg(les_pkg::CFG_BETA, pick_extreme());
			write_reg(les_pkg::CFG_RHO, pick_extreme());
			write_reg(les_pkg::CFG_TIME_STEP, pick_extreme());
			write_reg(les_pkg::CFG_START_X, pick_extreme());
			write_reg(les_pkg::CFG_START_Y, pick_extreme());
			write_reg(les_pkg::CFG_START_Z, pick_extreme());
			write_reg(les_pkg::CFG_RUN_LENGTH, $urandom_range(0, 8));
		end
	endtask

	initial begin
		int kind;
		int n;
		int pct;
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = les_pkg::CFG_SIGMA;
		cfg_data = '0;
		step_ch.valid = 1'b0;
		step_ch.restart = 1'b0;
		sent = 0;
		cycle_count = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset coefficients, restart held for two requests
		send_one(1'b0);
		send_one(1'b0);
		send_one(1'b1);
		send_one(1'b1);
		send_one(1'b0);
		settle();

		// shortest run, every step ends the run; then a run length of three
		write_reg(les_pkg::CFG_RUN_LENGTH, 32'd1);
		write_reg(les_pkg::CFG_START_X, 32'd0);
		write_reg(les_pkg::CFG_START_Y, 32'd0);
		write_reg(les_pkg::CFG_START_Z, 32'd0);
		send_one(1'b1);
		send_one(1'b0);
		send_one(1'b0);
		settle();
		write_reg(les_pkg::CFG_RUN_LENGTH, 32'd3);
		send_one(1'b1);
		repeat (4) send_one(1'b0);
		settle();

		// top of most ranges, bottom for beta and start y, run length zero
		write_reg(les_pkg::CFG_SIGMA, 32'h7fff_ffff);
		write_reg(les_pkg::CFG_BETA, 32'h8000_0000);
		write_reg(les_pkg::CFG_RHO, 32'h7fff_ffff);
		write_reg(les_pkg::CFG_TIME_STEP, 32'h7fff_ffff);
		write_reg(les_pkg::CFG_START_X, 32'h7fff_ffff);
		write_reg(les_pkg::CFG_START_Y, 32'h8000_0000);
		write_reg(les_pkg::CFG_START_Z, 32'h7fff_ffff);
		write_reg(les_pkg::CFG_RUN_LENGTH, 32'd0);
		send_one(1'b1);
		send_one(1'b0);
		send_one(1'b0);
		settle();

		// bottom of most ranges, top for beta and run length, zero time step
		write_reg(les_pkg::CFG_SIGMA, 32'h8000_0000);
		write_reg(les_pkg::CFG_BETA, 32'h7fff_ffff);
		write_reg(les_pkg::CFG_RHO, 32'h8000_0000);
		write_reg(les_pkg::CFG_TIME_STEP, 32'd0);
		write_reg(les_pkg::CFG_START_X, 32'h8000_0000);
		write_reg(les_pkg::CFG_START_Y, 32'h8000_0000);
		write_reg(les_pkg::CFG_START_Z, 32'h8000_0000);
		write_reg(les_pkg::CFG_RUN_LENGTH, 32'hffff);
		send_one(1'b1);
		send_one(1'b0);
		send_one(1'b0);
		settle();

		// run length lowered below the step count mid-run
		write_defaults();
		write_reg(les_pkg::CFG_RUN_LENGTH, 32'd10);
		send_one(1'b1);
		send_one(1'b0);
		settle();
		write_reg(les_pkg::CFG_RUN_LENGTH, 32'd1);
		send_one(1'b0);
		send_one(1'b0);
		send_one(1'b1);
		settle();

		target = sent + RANDOM_ITEMS;
		while (sent < target) begin
			kind = $urandom_range(0, 9);
			random_config(kind);
			n = $urandom_range(10, 50);
			case ($urandom_range(0, 4))
				0: pct = 100;
				1: pct = 0;
				default: pct = 8;
			endcase
			if ($urandom_range(0, 3) != 0) begin
				send_one(1'b1);
				n--;
			end
			send_batch(n, pct);
			settle();
		end

		repeat (30) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("lorenz_euler_step_unit regression: pass");
		end else begin
			$display("lorenz_euler_step_unit regression: fail");
		end
		$finish;
	end

endmodule
